// ----- design/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types for the trial division primality test: sequencer states,
// divisor selection codes and the request/response structs of the
// remainder unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        D_TWO,
        D_THREE,
        D_LO,
        D_HI
    } t_dsel;

    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_div_rsp;

    localparam int unsigned FIRST_DIVISOR = 5;
    localparam int unsigned WHEEL_STEP    = 6;
    localparam int unsigned PAIR_OFFSET   = 2;

endpackage

// ----- design/tdp_div.sv -----
// ----------------------------------------------------------------------------
// tdp_div
// Serial restoring remainder unit. Takes one dividend bit per cycle and
// reports on completion whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdp_div
    import tdp_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16,
    parameter int unsigned DIV_WIDTH   = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_req               i_req,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]   i_divisor,
    output t_div_rsp               o_rsp
);

    localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [DIV_WIDTH-1:0]   r_dvs;

    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DIV_WIDTH'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= CNT_WIDTH'(VALUE_WIDTH - 1);
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

// ----- design/trial_division_primality_test.sv -----
// Values up to 3 are answered without the remainder unit; any other value takes
// up to 2 + 2*floor((sqrt(N)+1)/6) trial remainders.
// Transactions are handled one at a time, limited by the single bit-serial
// remainder unit.
// Reset: synchronous active-low, returns the sequencer to idle.
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Primality test by trial division over the 6k +/- 1 wheel, sequencing one
// shared serial remainder unit.
// ----------------------------------------------------------------------------
module trial_division_primality_test
    import tdp_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_number,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_is_prime
);

    localparam int unsigned DW  = VALUE_WIDTH / 2 + 2;
    localparam int unsigned SQW = 2 * DW;

    t_state                 r_state, n_state;
    t_dsel                  r_sel, n_sel;
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [DW-1:0]          r_d, n_d;
    logic [SQW-1:0]         r_sq, n_sq;
    logic                   r_prime, n_prime;

    t_div_req               div_req;
    t_div_rsp               div_rsp;
    logic [DW-1:0]          divisor;
    logic [SQW-1:0]         n_ext;
    logic [SQW-1:0]         sq_step;

    assign n_ext   = SQW'(r_n);
    assign sq_step = r_sq + SQW'({r_d, 3'b000}) + SQW'({r_d, 2'b00})
                     + SQW'(WHEEL_STEP * WHEEL_STEP);

    always_comb begin
        case (r_sel)
            D_TWO:   divisor = DW'(2);
            D_THREE: divisor = DW'(3);
            D_LO:    divisor = r_d;
            D_HI:    divisor = r_d + DW'(PAIR_OFFSET);
            default: divisor = r_d;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_n     = r_n;
        n_d     = r_d;
        n_sq    = r_sq;
        n_prime = r_prime;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n = i_number;
                    n_sel = D_TWO;
                    if (i_number <= VALUE_WIDTH'(3)) begin
                        n_prime = (i_number > VALUE_WIDTH'(1));
                        n_state = S_OUT;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.zero) begin
                        n_prime = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        case (r_sel)
                            D_TWO: begin
                                n_sel   = D_THREE;
                                n_state = S_START;
                            end
                            D_THREE: begin
                                n_d  = DW'(FIRST_DIVISOR);
                                n_sq = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
                                n_sel = D_LO;
                                if (SQW'(FIRST_DIVISOR * FIRST_DIVISOR) > n_ext) begin
                                    n_prime = 1'b1;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_START;
                                end
                            end
                            D_LO: begin
                                n_sel   = D_HI;
                                n_state = S_START;
                            end
                            default: begin
                                n_d   = r_d + DW'(WHEEL_STEP);
                                n_sq  = sq_step;
                                n_sel = D_LO;
                                if (sq_step > n_ext) begin
                                    n_prime = 1'b1;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_START;
                                end
                            end
                        endcase
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall       = (r_state != S_IDLE);
        o_valid       = (r_state == S_OUT);
        div_req.start = (r_state == S_START);
    end

    assign o_is_prime = r_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel   <= n_sel;
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
    end

    tdp_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_n),
        .i_divisor  (divisor),
        .o_rsp      (div_rsp)
    );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trial_division_primality_test. A short table of
// hand-picked numbers (small values, wheel squares and pair products, the
// 16-bit extremes) is followed by random numbers that favour 6k +/- 1
// candidates. Each verdict is checked against the table's value where given,
// else a behavioural prime test, with random idling on both handshake sides.
// ----------------------------------------------------------------------------
module testbench;
    import tdp_pkg::*;

    localparam int unsigned VALUE_WIDTH  = 16;
    localparam int          N_DIRECTED   = 23;
    localparam int          N_RANDOM     = 400;
    localparam int          IDLE_PERCENT = 17;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] number;
        bit                     typed;
        bit                     is_prime;
    } t_directed_row;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] number;
        bit                     is_prime;
    } t_verdict;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_stall;
    logic [VALUE_WIDTH-1:0] i_number   = '0;
    logic                   o_valid;
    logic                   i_stall    = 1'b0;
    logic                   o_is_prime;

    bit       calm        = 1'b0;
    t_verdict verdicts[$];
    int       failures    = 0;
    int       primes_seen = 0;
    int       composites_seen = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{16'd0,     1'b1, 1'b0},
        '{16'd1,     1'b1, 1'b0},
        '{16'd2,     1'b1, 1'b1},
        '{16'd3,     1'b1, 1'b1},
        '{16'd4,     1'b1, 1'b0},
        '{16'd5,     1'b0, 1'b0},
        '{16'd6,     1'b0, 1'b0},
        '{16'd9,     1'b0, 1'b0},
        '{16'd25,    1'b0, 1'b0},
        '{16'd35,    1'b0, 1'b0},
        '{16'd49,    1'b0, 1'b0},
        '{16'd121,   1'b0, 1'b0},
        '{16'd169,   1'b0, 1'b0},
        '{16'd8633,  1'b0, 1'b0},
        '{16'd58081, 1'b0, 1'b0},
        '{16'd63001, 1'b0, 1'b0},
        '{16'd65521, 1'b0, 1'b0},
        '{16'd65519, 1'b0, 1'b0},
        '{16'd32768, 1'b1, 1'b0},
        '{16'd21845, 1'b0, 1'b0},
        '{16'd43690, 1'b1, 1'b0},
        '{16'd65534, 1'b1, 1'b0},
        '{16'd65535, 1'b1, 1'b0}
    };

    trial_division_primality_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_number  (i_number),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_is_prime(o_is_prime)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #24000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit predict_prime(input logic [VALUE_WIDTH-1:0] n);
        int unsigned v;
        int unsigned d;
        v = 32'(n);
        if (v <= 3)
            return v > 1;
        if (v % 2 == 0 || v % 3 == 0)
            return 1'b0;
        for (d = FIRST_DIVISOR; d * d <= v; d += WHEEL_STEP) begin
            if (v % d == 0 || v % (d + PAIR_OFFSET) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_number();
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(99);
        if (sel < 40)
            return VALUE_WIDTH'($urandom_range(1023));
        if (sel < 65)
            return VALUE_WIDTH'($urandom);
        k = $urandom_range(10922, 1) * WHEEL_STEP;
        return $urandom_range(1) ? VALUE_WIDTH'(k + 1) : VALUE_WIDTH'(k - 1);
    endfunction

    task automatic send_number(input logic [VALUE_WIDTH-1:0] n, input bit typed,
                               input bit typed_prime);
        t_verdict due;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= n;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        due.number   = n;
        due.is_prime = typed ? typed_prime : predict_prime(n);
        verdicts = {verdicts, due};
    endtask

    task automatic wait_all_verdicts();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin : check_verdicts
        t_verdict due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts.size() == 0) begin
                $error("is_prime: no transaction outstanding, got %0d", o_is_prime);
                failures++;
            end else begin
                due = verdicts.pop_front();
                if (o_is_prime !== due.is_prime) begin
                    $error("is_prime for %0d: expected %0d, actual %0d",
                           due.number, due.is_prime, o_is_prime);
                    failures++;
                end
                if (due.is_prime)
                    primes_seen++;
                else
                    composites_seen++;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_number(directed_rows[r].number, directed_rows[r].typed,
                        directed_rows[r].is_prime);

        // hold off until the table has fully drained
        wait_all_verdicts();

        for (int t = 0; t < N_RANDOM; t++) begin
            calm <= (t >= 150 && t < 250);
            send_number(pick_number(), 1'b0, 1'b0);
        end

        wait_all_verdicts();
        calm <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Tested %0d numbers (%0d from the table, %0d random) with idling on both sides.",
                 N_DIRECTED + N_RANDOM, N_DIRECTED, N_RANDOM);
        $display("Verdicts received: %0d prime, %0d composite.", primes_seen, composites_seen);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- trial_division_primality_test.f -----
design/tdp_pkg.sv
design/tdp_div.sv
design/trial_division_primality_test.sv
tb/testbench.sv
